// ===== src/ille_pkg.sv =====
`default_nettype none

package ille_pkg;

    localparam int NODE_SLOTS = 32;
    localparam int VALUE_BITS = 32;

    localparam int SLOT_W = $clog2(NODE_SLOTS);
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;
    localparam int CMP_W  = (SLOT_W > POS_W) ? SLOT_W : POS_W;
    localparam int XW     = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_INSERT = 2'd2,
        MODE_REMOVE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  data_in;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        status_t            status;
        logic [CNT_W-1:0]   item_count;
    } rsp_t;

    typedef struct packed {
        mode_t              mode;
        logic [POS_W-1:0]   position;
        value_t             value;
        status_t            status;
        logic [CNT_W-1:0]   item_count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Reset contents of the link store: sentinel self-linked, free chain 1..N-1.
    function automatic slot_t link_init(slot_t s);
        slot_t r;
        if (s == '0 || s == SLOT_W'(NODE_SLOTS - 1)) begin
            r = '0;
        end
        else begin
            r = s + SLOT_W'(1);
        end
        return r;
    endfunction

    function automatic logic [CMP_W-1:0] pos_ext(logic [POS_W-1:0] p);
        return CMP_W'(p);
    endfunction

    function automatic logic [CMP_W-1:0] slot_ext(slot_t s);
        return CMP_W'(s);
    endfunction

    function automatic logic [CNT_W-1:0] item_count_of(slot_t c);
        logic [CMP_W-1:0] x;
        x = CMP_W'(c);
        return x[CNT_W-1:0];
    endfunction

    function automatic value_t value_of(logic [DATA_W-1:0] d);
        logic [XW-1:0] x;
        x = XW'(d);
        return x[VALUE_BITS-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] read_value_of(value_t v);
        logic [XW-1:0] x;
        x = XW'(v);
        return x[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/indexed_linked_list_engine.sv =====
// Channel   Valid      Stall      Beat   Moves
// request   req_valid  req_stall  req    mode, position, data_in
// response  rsp_valid  rsp_stall  rsp    read_value, status, item_count
//
// A request beat is checked against the element count on arrival and queued.
// The back end walks one link per cycle from the sentinel towards position p;
// a flagged request skips the walk and goes straight to the response.
// After reset the list is empty and the free chain holds slots 1 to NODE_SLOTS-1.
// Requests keep flowing into a two-beat queue while a response waits on rsp_stall, until the queue is full.
`default_nettype none

module indexed_linked_list_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire ille_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output ille_pkg::rsp_t      rsp
);

    ille_pkg::fifo_stat_t q_stat;
    logic                 q_push;
    logic                 q_pop;
    ille_pkg::cmd_t       q_push_cmd;
    ille_pkg::cmd_t       q_pop_cmd;

    ille_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (q_push_cmd)
    );

    ille_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .stat     (q_stat)
    );

    ille_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_cmd     (q_pop_cmd),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== src/ille_cmd_fifo.sv =====
`default_nettype none

module ille_cmd_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ille_pkg::cmd_t     push_cmd,
    input  wire logic               pop,
    output ille_pkg::cmd_t          pop_cmd,
    output ille_pkg::fifo_stat_t    stat
);

    ille_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;
    logic           do_push;
    logic           do_pop;

    assign stat.full  = (fill_reg == 2'd2);
    assign stat.empty = (fill_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== src/ille_front.sv =====
`default_nettype none

module ille_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire ille_pkg::req_t     req,
    input  wire ille_pkg::fifo_stat_t q_stat,
    output logic                    q_push,
    output ille_pkg::cmd_t          q_cmd
);

    ille_pkg::slot_t   count_reg;
    ille_pkg::slot_t   count_next;
    logic              in_range;
    logic              full;
    ille_pkg::status_t status;

    // The element count is tracked here, so every beat is classified on arrival.
    always_comb
    begin
        if (req.mode == ille_pkg::MODE_INSERT)
        begin
            in_range = ille_pkg::pos_ext(req.position) <= ille_pkg::slot_ext(count_reg);
        end
        else
        begin
            in_range = ille_pkg::pos_ext(req.position) < ille_pkg::slot_ext(count_reg);
        end
        full = (count_reg == ille_pkg::SLOT_W'(ille_pkg::NODE_SLOTS - 1));

        count_next = count_reg;
        priority if (!in_range)
        begin
            status = ille_pkg::ST_RANGE;
        end
        else if (req.mode == ille_pkg::MODE_INSERT && full)
        begin
            status = ille_pkg::ST_FULL;
        end
        else
        begin
            status = ille_pkg::ST_OK;
            if (req.mode == ille_pkg::MODE_INSERT)
            begin
                count_next = count_reg + ille_pkg::SLOT_W'(1);
            end
            else if (req.mode == ille_pkg::MODE_REMOVE)
            begin
                count_next = count_reg - ille_pkg::SLOT_W'(1);
            end
        end
    end

    assign req_stall           = q_stat.full;
    assign q_push              = req_valid && !q_stat.full;
    assign q_cmd.mode          = req.mode;
    assign q_cmd.position      = req.position;
    assign q_cmd.value         = ille_pkg::value_of(req.data_in);
    assign q_cmd.status        = status;
    assign q_cmd.item_count    = ille_pkg::item_count_of(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (q_push)
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ille_back.sv =====
`default_nettype none

module ille_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ille_pkg::fifo_stat_t q_stat,
    input  wire ille_pkg::cmd_t     q_cmd,
    output logic                    q_pop,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output ille_pkg::rsp_t          rsp
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WALK  = 8'b0000_0010,
        S_VREAD = 8'b0000_0100,
        S_INS   = 8'b0000_1000,
        S_INS2  = 8'b0001_0000,
        S_REM   = 8'b0010_0000,
        S_REM2  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    ille_pkg::cmd_t            cmd_reg;
    ille_pkg::cmd_t            cmd_next;
    ille_pkg::slot_t           prev_reg;
    ille_pkg::slot_t           prev_next;
    ille_pkg::slot_t           node_reg;
    ille_pkg::slot_t           node_next;
    ille_pkg::slot_t           walk_reg;
    ille_pkg::slot_t           walk_next;
    ille_pkg::slot_t           free_head_reg;
    ille_pkg::slot_t           free_head_next;
    ille_pkg::slot_t           ins_reg;
    ille_pkg::slot_t           ins_next;
    ille_pkg::value_t          rv_reg;
    ille_pkg::value_t          rv_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    ille_pkg::rsp_t            rsp_reg;
    ille_pkg::rsp_t            rsp_next;

    ille_pkg::slot_t           link_mem [ille_pkg::NODE_SLOTS];
    logic [ille_pkg::NODE_SLOTS-1:0] link_vld_reg;
    logic                      link_re;
    ille_pkg::slot_t           link_raddr;
    logic                      link_we;
    ille_pkg::slot_t           link_waddr;
    ille_pkg::slot_t           link_wdata;
    ille_pkg::slot_t           link_mem_q_reg;
    ille_pkg::slot_t           link_init_q_reg;
    logic                      link_vld_q_reg;
    ille_pkg::slot_t           link_rdata;

    ille_pkg::value_t          value_mem [ille_pkg::NODE_SLOTS];
    logic                      value_re;
    ille_pkg::slot_t           value_raddr;
    logic                      value_we;
    ille_pkg::slot_t           value_waddr;
    ille_pkg::value_t          value_rdata_reg;

    logic                      walk_at_pos;
    logic                      rsp_free;

    assign link_rdata  = link_vld_q_reg ? link_mem_q_reg : link_init_q_reg;
    assign walk_at_pos = ille_pkg::slot_ext(walk_reg) == ille_pkg::pos_ext(cmd_reg.position);
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign q_pop       = (state_reg == S_IDLE) && !q_stat.empty;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        prev_next      = prev_reg;
        node_next      = node_reg;
        walk_next      = walk_reg;
        free_head_next = free_head_reg;
        ins_next       = ins_reg;
        rv_next        = rv_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        link_re        = 1'b0;
        link_raddr     = '0;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        value_re       = 1'b0;
        value_raddr    = '0;
        value_we       = 1'b0;
        value_waddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    cmd_next  = q_cmd;
                    rv_next   = '0;
                    prev_next = '0;
                    walk_next = '0;
                    if (q_cmd.status == ille_pkg::ST_OK)
                    begin
                        link_re    = 1'b1;
                        link_raddr = '0;
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                if (!walk_at_pos)
                begin
                    prev_next  = link_rdata;
                    walk_next  = walk_reg + ille_pkg::SLOT_W'(1);
                    link_re    = 1'b1;
                    link_raddr = link_rdata;
                end
                else
                begin
                    node_next = link_rdata;
                    unique case (cmd_reg.mode)
                        ille_pkg::MODE_READ:
                        begin
                            value_re    = 1'b1;
                            value_raddr = link_rdata;
                            state_next  = S_VREAD;
                        end
                        ille_pkg::MODE_WRITE:
                        begin
                            value_we    = 1'b1;
                            value_waddr = link_rdata;
                            state_next  = S_DONE;
                        end
                        ille_pkg::MODE_INSERT:
                        begin
                            link_re     = 1'b1;
                            link_raddr  = free_head_reg;
                            value_we    = 1'b1;
                            value_waddr = free_head_reg;
                            state_next  = S_INS;
                        end
                        ille_pkg::MODE_REMOVE:
                        begin
                            link_re    = 1'b1;
                            link_raddr = link_rdata;
                            state_next = S_REM;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_VREAD:
            begin
                rv_next    = value_rdata_reg;
                state_next = S_DONE;
            end
            S_INS:
            begin
                link_we        = 1'b1;
                link_waddr     = free_head_reg;
                link_wdata     = node_reg;
                ins_next       = free_head_reg;
                free_head_next = link_rdata;
                state_next     = S_INS2;
            end
            S_INS2:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = ins_reg;
                state_next = S_DONE;
            end
            S_REM:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rdata;
                state_next = S_REM2;
            end
            S_REM2:
            begin
                link_we        = 1'b1;
                link_waddr     = node_reg;
                link_wdata     = free_head_reg;
                free_head_next = node_reg;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.read_value = ille_pkg::read_value_of(rv_reg);
                    rsp_next.status     = cmd_reg.status;
                    rsp_next.item_count = cmd_reg.item_count;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= ille_pkg::SLOT_W'(1);
            rsp_valid_reg <= 1'b0;
            link_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            rsp_valid_reg <= rsp_valid_next;
            if (link_we)
            begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        prev_reg <= prev_next;
        node_reg <= node_next;
        walk_reg <= walk_next;
        ins_reg  <= ins_next;
        rv_reg   <= rv_next;
        rsp_reg  <= rsp_next;
    end

    // Slots never written read back their reset link through the valid bits.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_mem_q_reg  <= link_mem[link_raddr];
            link_init_q_reg <= ille_pkg::link_init(link_raddr);
            link_vld_q_reg  <= link_vld_reg[link_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_waddr] <= cmd_reg.value;
        end
        if (value_re)
        begin
            value_rdata_reg <= value_mem[value_raddr];
        end
    end

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |->
            ille_pkg::slot_ext(walk_reg) <= ille_pkg::pos_ext(cmd_reg.position))
        else $error("walk counter passed the target position");

    a_insert_not_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> free_head_reg != '0)
        else $error("insert took the sentinel slot from the free chain");

    a_remove_not_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> node_reg != '0)
        else $error("remove targeted the sentinel slot");

    a_flagged_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_cmd.status != ille_pkg::ST_OK) |=> (state_reg == S_DONE))
        else $error("flagged command entered the walk");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp_free) |=> (rsp_valid_reg && state_reg == S_IDLE))
        else $error("finished command did not reach the result register");

endmodule

`default_nettype wire
